// ===== hdl/smsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsp_pkg: shared constants for the staged mute/select panel
// Channel count, configuration register map and register reset values.
// ----------------------------------------------------------------------------
package smsp_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int CH_BITS      = 3;
    localparam logic [CH_BITS-1:0] CH_MASK =
        CH_BITS'(((1 << NUM_CHANNELS) - 1) & ((1 << CH_BITS) - 1));

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TIMEOUT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_DIVISOR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_SEED    = 2'd2;

    localparam logic [15:0] HOLD_TIMEOUT_RST  = 16'd1000;
    localparam logic [7:0]  BLINK_DIVISOR_RST = 8'd96;
    localparam logic [5:0]  BLINK_SEED_RST    = 6'b100000;

    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

endpackage

// ===== hdl/staged_mute_select_panel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_mute_select_panel: three-channel mute/select panel controller
// Tick transactions sample the stage, mute and select buttons; clock-edge
// transactions commit armed staged changes. Each transaction yields one
// result: control lines, a 16-bit LED word with blink overlay, armed flag.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------
//  in        in_valid/in_ready    operation, stage_pressed, mute_pressed,
//                                 select_pressed
//  out       out_valid/out_ready  mute_lines, select_lines, led_word, armed
//  config    APB psel/penable     paddr, pwdata, prdata (hold_timeout at 0x0,
//                                 blink_divisor at 0x4, blink_seed at 0x8)
//
//  One transaction per clock. Panel state and the result register are both
//  loaded at the accepting edge; the result is valid the cycle after.
//  in_ready is high whenever the result register is empty or being drained,
//  so a stalled output holds one result and blocks new input only then.
//  Reset clears all panel state; the blink pattern loads the blink_seed
//  reset value (0b100000).
// ----------------------------------------------------------------------------
module staged_mute_select_panel
    import smsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic                stage_pressed,
    input  logic [CH_BITS-1:0]  mute_pressed,
    input  logic [CH_BITS-1:0]  select_pressed,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [CH_BITS-1:0]  mute_lines,
    output logic [CH_BITS-1:0]  select_lines,
    output logic [15:0]         led_word,
    output logic                armed,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // ---------------- configuration registers ----------------
    logic [15:0] hold_timeout_reg;
    logic [7:0]  blink_divisor_reg;
    logic [5:0]  blink_seed_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_timeout_reg  <= HOLD_TIMEOUT_RST;
            blink_divisor_reg <= BLINK_DIVISOR_RST;
            blink_seed_reg    <= BLINK_SEED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_HOLD_TIMEOUT:  hold_timeout_reg  <= pwdata[15:0];
                REG_BLINK_DIVISOR: blink_divisor_reg <= pwdata[7:0];
                REG_BLINK_SEED:    blink_seed_reg    <= pwdata[5:0];
                default:           ; // unmapped address: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_HOLD_TIMEOUT:  prdata = {16'd0, hold_timeout_reg};
            REG_BLINK_DIVISOR: prdata = {24'd0, blink_divisor_reg};
            REG_BLINK_SEED:    prdata = {26'd0, blink_seed_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- panel state ----------------
    logic               armed_flag_reg,   armed_flag_next;
    logic               held_flag_reg,    held_flag_next;
    logic [15:0]        hold_count_reg,   hold_count_next;
    logic [CH_BITS-1:0] pend_mute_reg,    pend_mute_next;
    logic [CH_BITS-1:0] pend_sel_reg,     pend_sel_next;
    logic [CH_BITS-1:0] prev_mute_reg,    prev_mute_next;
    logic [CH_BITS-1:0] prev_sel_reg,     prev_sel_next;
    logic [CH_BITS-1:0] mute_state_reg,   mute_state_next;
    logic [CH_BITS-1:0] sel_state_reg,    sel_state_next;
    logic [5:0]         blink_pat_reg,    blink_pat_next;
    logic [7:0]         blink_cnt_reg,    blink_cnt_next;
    logic [15:0]        leds_next;

    // result register
    logic               out_valid_reg;
    logic [CH_BITS-1:0] out_mute_reg;
    logic [CH_BITS-1:0] out_sel_reg;
    logic [15:0]        out_leds_reg;
    logic               out_armed_reg;

    logic               accept;
    logic [CH_BITS-1:0] mb;
    logic [CH_BITS-1:0] sb;
    logic [CH_BITS-1:0] mrise;
    logic [CH_BITS-1:0] srise;
    logic [7:0]         cnt_inc;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign mb       = mute_pressed & CH_MASK;
    assign sb       = select_pressed & CH_MASK;

    always_comb
    begin
        armed_flag_next = armed_flag_reg;
        held_flag_next  = held_flag_reg;
        hold_count_next = hold_count_reg;
        pend_mute_next  = pend_mute_reg;
        pend_sel_next   = pend_sel_reg;
        prev_mute_next  = prev_mute_reg;
        prev_sel_next   = prev_sel_reg;
        mute_state_next = mute_state_reg;
        sel_state_next  = sel_state_reg;
        blink_pat_next  = blink_pat_reg;
        blink_cnt_next  = blink_cnt_reg;
        mrise           = '0;
        srise           = '0;
        cnt_inc         = blink_cnt_reg + 8'd1;

        if (operation)
        begin
            // clock edge: commit only when armed and stage released
            if (armed_flag_reg && !held_flag_reg)
            begin
                mute_state_next = (mute_state_reg ^ pend_mute_reg) & CH_MASK;
                sel_state_next  = (sel_state_reg ^ pend_sel_reg) & CH_MASK;
                pend_mute_next  = '0;
                pend_sel_next   = '0;
                armed_flag_next = 1'b0;
            end
        end
        else
        begin
            // stage button first
            if (stage_pressed)
            begin
                if (!held_flag_reg)
                begin
                    held_flag_next  = 1'b1;
                    hold_count_next = '0;
                end
                else
                begin
                    if ((hold_count_reg >= hold_timeout_reg) && armed_flag_reg)
                    begin
                        armed_flag_next = 1'b0;
                        pend_mute_next  = '0;
                        pend_sel_next   = '0;
                    end
                    if (hold_count_reg != HOLD_MAX)
                        hold_count_next = hold_count_reg + 16'd1;
                end
            end
            else
            begin
                if (held_flag_reg)
                begin
                    if (armed_flag_reg)
                    begin
                        mute_state_next = (mute_state_reg ^ pend_mute_reg) & CH_MASK;
                        sel_state_next  = (sel_state_reg ^ pend_sel_reg) & CH_MASK;
                        pend_mute_next  = '0;
                        pend_sel_next   = '0;
                        armed_flag_next = 1'b0;
                    end
                    else if ((pend_mute_reg | pend_sel_reg) != '0)
                    begin
                        armed_flag_next = 1'b1;
                    end
                end
                held_flag_next = 1'b0;
            end

            // button press edges: stage or toggle at once
            mrise = mb & ~prev_mute_reg;
            srise = sb & ~prev_sel_reg;
            if (held_flag_next)
            begin
                pend_mute_next = pend_mute_next ^ mrise;
                pend_sel_next  = pend_sel_next ^ srise;
            end
            else
            begin
                mute_state_next = mute_state_next ^ mrise;
                sel_state_next  = sel_state_next ^ srise;
            end
            prev_mute_next = mb;
            prev_sel_next  = sb;

            // blink rotation after the LED word is formed
            if (cnt_inc >= blink_divisor_reg)
            begin
                blink_pat_next = {blink_pat_reg[4:0], blink_pat_reg[5]};
                blink_cnt_next = '0;
            end
            else
            begin
                blink_cnt_next = cnt_inc;
            end
        end
    end

    // LED word from post-update state and the pre-rotation blink pattern
    always_comb
    begin
        leds_next = '0;
        for (int i = 0; i < CH_BITS; i++)
        begin
            if (i < NUM_CHANNELS)
            begin
                if (sel_state_next[i])
                    leds_next[3 + 2*i] = 1'b1;
                else
                    leds_next[2 + 2*i] = 1'b1;
                leds_next[13 + i] = mute_state_next[i];
            end
        end
        if (armed_flag_next || held_flag_next)
        begin
            for (int i = 0; i < CH_BITS; i++)
            begin
                if (pend_mute_next[i])
                    leds_next[13 + i] = leds_next[13 + i] ^ blink_pat_reg[0];
                if (pend_sel_next[i])
                    leds_next[11 - i] = leds_next[11 - i] ^ blink_pat_reg[0];
            end
            if (armed_flag_next)
                leds_next[8] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_flag_reg <= 1'b0;
            held_flag_reg  <= 1'b0;
            hold_count_reg <= '0;
            pend_mute_reg  <= '0;
            pend_sel_reg   <= '0;
            prev_mute_reg  <= '0;
            prev_sel_reg   <= '0;
            mute_state_reg <= '0;
            sel_state_reg  <= '0;
            blink_pat_reg  <= BLINK_SEED_RST;
            blink_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            armed_flag_reg <= armed_flag_next;
            held_flag_reg  <= held_flag_next;
            hold_count_reg <= hold_count_next;
            pend_mute_reg  <= pend_mute_next;
            pend_sel_reg   <= pend_sel_next;
            prev_mute_reg  <= prev_mute_next;
            prev_sel_reg   <= prev_sel_next;
            mute_state_reg <= mute_state_next;
            sel_state_reg  <= sel_state_next;
            blink_pat_reg  <= blink_pat_next;
            blink_cnt_reg  <= blink_cnt_next;
        end
    end

    // result register: loads on accept, clears when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_mute_reg  <= mute_state_next;
            out_sel_reg   <= sel_state_next;
            out_leds_reg  <= leds_next;
            out_armed_reg <= armed_flag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mute_lines   = out_mute_reg;
    assign select_lines = out_sel_reg;
    assign led_word     = out_leds_reg;
    assign armed        = out_armed_reg;

endmodule

// ===== dv/staged_mute_select_panel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_mute_select_panel_tb: self-checking bench for the mute/select panel
// Drives tick and clock-edge transactions through the valid/ready input,
// keeps a cycle-free shadow of the panel state, and compares every result
// field by field. Configuration changes go through the APB port between
// phases, with read-back.
// ----------------------------------------------------------------------------
module staged_mute_select_panel_tb;

    import smsp_pkg::*;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_EDGE = 1'b1
    } panel_op_e;

    typedef struct packed {
        panel_op_e          op;
        logic               stage;
        logic [CH_BITS-1:0] mute_btn;
        logic [CH_BITS-1:0] sel_btn;
    } panel_item_t;

    typedef struct packed {
        logic [CH_BITS-1:0] mute_lines;
        logic [CH_BITS-1:0] select_lines;
        logic [15:0]        led_word;
        logic               armed;
    } panel_result_t;

    // ------------------------------------------------------------------------
    // Shadow of the panel: register copies, flag state, and the queue of
    // results the block still owes us.
    // ------------------------------------------------------------------------
    class panel_shadow;
        logic [15:0]        hold_timeout;
        logic [7:0]         blink_divisor;
        logic [5:0]         blink_seed;

        logic               armed_f;
        logic               held_f;
        logic [15:0]        hold_cnt;
        logic [CH_BITS-1:0] pend_mute;
        logic [CH_BITS-1:0] pend_sel;
        logic [CH_BITS-1:0] prev_mute;
        logic [CH_BITS-1:0] prev_sel;
        logic [CH_BITS-1:0] mute_st;
        logic [CH_BITS-1:0] sel_st;
        logic [5:0]         blink_pat;
        logic [7:0]         blink_cnt;

        panel_result_t      owed_results[$];

        int errors;
        int checked;
        int n_ticks;
        int n_edges;
        int n_armed;
        int n_committed;
        int n_discarded;

        function new();
            hold_timeout  = HOLD_TIMEOUT_RST;
            blink_divisor = BLINK_DIVISOR_RST;
            blink_seed    = BLINK_SEED_RST;
            armed_f   = 1'b0;
            held_f    = 1'b0;
            hold_cnt  = '0;
            pend_mute = '0;
            pend_sel  = '0;
            prev_mute = '0;
            prev_sel  = '0;
            mute_st   = '0;
            sel_st    = '0;
            blink_pat = BLINK_SEED_RST;
            blink_cnt = '0;
        endfunction

        // blink_seed is never used by the panel logic, so a write just updates the copy
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_HOLD_TIMEOUT:  hold_timeout  = value[15:0];
                REG_BLINK_DIVISOR: blink_divisor = value[7:0];
                default:           blink_seed    = value[5:0];
            endcase
        endfunction

        function void commit_staged();
            mute_st   = (mute_st ^ pend_mute) & CH_MASK;
            sel_st    = (sel_st ^ pend_sel) & CH_MASK;
            pend_mute = '0;
            pend_sel  = '0;
            armed_f   = 1'b0;
            n_committed++;
        endfunction

        function logic [15:0] led_image();
            logic [15:0] w;
            logic        bl;
            w  = '0;
            bl = blink_pat[0];
            for (int i = 0; i < CH_BITS; i++) begin
                if (CH_MASK[i]) begin
                    if (sel_st[i])
                        w[3 + 2 * i] = 1'b1;
                    else
                        w[2 + 2 * i] = 1'b1;
                    if (mute_st[i])
                        w[13 + i] = 1'b1;
                end
            end
            if (armed_f || held_f) begin
                for (int i = 0; i < CH_BITS; i++) begin
                    if (pend_mute[i])
                        w[13 + i] = w[13 + i] ^ bl;
                    if (pend_sel[i])
                        w[11 - i] = w[11 - i] ^ bl;
                end
                if (armed_f)
                    w[8] = 1'b1;
            end
            return w;
        endfunction

        // Advance the panel by one accepted transaction and queue its result
        function void advance(panel_item_t it);
            logic [CH_BITS-1:0] mb;
            logic [CH_BITS-1:0] sb;
            logic [CH_BITS-1:0] mrise;
            logic [CH_BITS-1:0] srise;
            panel_result_t      want;
            mb = it.mute_btn & CH_MASK;
            sb = it.sel_btn & CH_MASK;
            if (it.op == OP_EDGE) begin
                n_edges++;
                if (armed_f && !held_f)
                    commit_staged();
                want.led_word = led_image();
            end
            else begin
                n_ticks++;
                if (it.stage) begin
                    if (!held_f) begin
                        held_f   = 1'b1;
                        hold_cnt = '0;
                    end
                    else begin
                        if (hold_cnt >= hold_timeout && armed_f) begin
                            armed_f   = 1'b0;
                            pend_mute = '0;
                            pend_sel  = '0;
                            n_discarded++;
                        end
                        if (hold_cnt != HOLD_MAX)
                            hold_cnt = hold_cnt + 16'd1;
                    end
                end
                else begin
                    if (held_f) begin
                        if (armed_f)
                            commit_staged();
                        else if ((pend_mute | pend_sel) != '0) begin
                            armed_f = 1'b1;
                            n_armed++;
                        end
                    end
                    held_f = 1'b0;
                end

                mrise = mb & ~prev_mute;
                srise = sb & ~prev_sel;
                if (held_f) begin
                    pend_mute = pend_mute ^ mrise;
                    pend_sel  = pend_sel ^ srise;
                end
                else begin
                    mute_st = mute_st ^ mrise;
                    sel_st  = sel_st ^ srise;
                end
                prev_mute = mb;
                prev_sel  = sb;

                // LED word is taken before the blink rotation
                want.led_word = led_image();

                blink_cnt = blink_cnt + 8'd1;
                if (blink_cnt >= blink_divisor) begin
                    blink_pat = {blink_pat[4:0], blink_pat[5]};
                    blink_cnt = '0;
                end
            end
            want.mute_lines   = mute_st;
            want.select_lines = sel_st;
            want.armed        = armed_f;
            owed_results.push_back(want);
        endfunction

        function void compare_panel(logic [CH_BITS-1:0] m, logic [CH_BITS-1:0] s,
                                    logic [15:0] leds, logic a);
            panel_result_t want;
            if (owed_results.size() == 0) begin
                errors++;
                $error("result with nothing outstanding: mute %0h select %0h led %04h",
                       m, s, leds);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (m !== want.mute_lines) begin
                errors++;
                $error("mute_lines: expected %0h, got %0h", want.mute_lines, m);
            end
            if (s !== want.select_lines) begin
                errors++;
                $error("select_lines: expected %0h, got %0h", want.select_lines, s);
            end
            if (leds !== want.led_word) begin
                errors++;
                $error("led_word: expected %04h, got %04h", want.led_word, leds);
            end
            if (a !== want.armed) begin
                errors++;
                $error("armed: expected %0b, got %0b", want.armed, a);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                operation;
    logic                stage_pressed;
    logic [CH_BITS-1:0]  mute_pressed;
    logic [CH_BITS-1:0]  select_pressed;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CH_BITS-1:0]  mute_lines;
    logic [CH_BITS-1:0]  select_lines;
    logic [15:0]         led_word;
    logic                armed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    panel_shadow shadow = new();

    bit gaps_on    = 1'b1;  // random idle cycles on both channels
    int stall_left = 0;     // long output hold-off, counted down by the receiver
    int items_sent = 0;
    int n_settings = 0;

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    staged_mute_select_panel i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .stage_pressed  (stage_pressed),
        .mute_pressed   (mute_pressed),
        .select_pressed (select_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mute_lines     (mute_lines),
        .select_lines   (select_lines),
        .led_word       (led_word),
        .armed          (armed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. A pending hold-off takes
    // priority over the random idling so the block fills up and backs off
    // its input.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (gaps_on && $urandom_range(99) < 12)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Output monitor: every accepted result is checked against the shadow
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            shadow.compare_panel(mute_lines, select_lines, led_word, armed);
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All of them start and end just after a falling edge.
    // ------------------------------------------------------------------------
    function automatic panel_item_t panel_item(panel_op_e op, logic st,
                                               logic [CH_BITS-1:0] m,
                                               logic [CH_BITS-1:0] s);
        panel_item_t it;
        it.op       = op;
        it.stage    = st;
        it.mute_btn = m;
        it.sel_btn  = s;
        return it;
    endfunction

    // Buttons mostly released, so presses produce fresh rising edges
    function automatic logic [CH_BITS-1:0] press_bits();
        return ($urandom_range(1) == 1) ? CH_BITS'($urandom_range(7)) : '0;
    endfunction

    // One input transaction: optional idle cycles, then valid held until taken.
    // The shadow is advanced at the accepting edge.
    task automatic drive_item(input panel_item_t it);
        while (gaps_on && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= it.op;
        stage_pressed  <= it.stage;
        mute_pressed   <= it.mute_btn;
        select_pressed <= it.sel_btn;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.advance(it);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop offering input and let every owed result come back; the block
    // holds at most one registered result.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (shadow.owed_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        case (idx)
            REG_HOLD_TIMEOUT:  mask = 32'h0000_FFFF;
            REG_BLINK_DIVISOR: mask = 32'h0000_00FF;
            default:           mask = 32'h0000_003F;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value & mask;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow.write_reg(idx, value & mask);
        if ((got & mask) !== (value & mask)) begin
            shadow.errors++;
            $error("register %0d read-back: expected %0h, got %0h",
                   idx, value & mask, got & mask);
        end
    endtask

    task automatic load_settings(input logic [15:0] tmo, input logic [7:0] div,
                                 input logic [5:0] seed);
        cfg_write(REG_HOLD_TIMEOUT, 32'(tmo));
        cfg_write(REG_BLINK_DIVISOR, 32'(div));
        cfg_write(REG_BLINK_SEED, 32'(seed));
        n_settings++;
    endtask

    // A well-formed staging gesture: hold stage with random presses, release
    // (arms or commits), then maybe commit by clock edge or by a short tap.
    // Some holds run long enough to hit the hold timeout.
    task automatic staged_sequence();
        int hold_len;
        hold_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int k = 0; k < hold_len; k++)
            drive_item(panel_item(OP_TICK, 1'b1, press_bits(), press_bits()));
        drive_item(panel_item(OP_TICK, 1'b0, press_bits(), press_bits()));
        case ($urandom_range(3))
            0: drive_item(panel_item(OP_EDGE, 1'($urandom_range(1)),
                                     CH_BITS'($urandom_range(7)),
                                     CH_BITS'($urandom_range(7))));
            1: begin
                drive_item(panel_item(OP_TICK, 1'b1, '0, '0));
                drive_item(panel_item(OP_TICK, 1'b0, '0, '0));
            end
            default: ;
        endcase
    endtask

    // Unstructured transaction: any operation, any button levels
    task automatic noise_item();
        panel_op_e op;
        op = ($urandom_range(5) == 0) ? OP_EDGE : OP_TICK;
        drive_item(panel_item(op, 1'($urandom_range(1)), CH_BITS'($urandom_range(7)),
                              CH_BITS'($urandom_range(7))));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] tmo;
        logic [7:0]  div;
        logic [5:0]  seed;
        int          phase_end;
        bit          pressure_done;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_TICK;
        stage_pressed  = 1'b0;
        mute_pressed   = '0;
        select_pressed = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pressure_done  = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed, reset settings ---
        // clock edge with nothing armed; button fields must be ignored
        drive_item(panel_item(OP_EDGE, 1'b1, 3'b111, 3'b111));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        // direct toggles on all channels, then held levels (no new edges)
        drive_item(panel_item(OP_TICK, 1'b0, 3'b111, 3'b111));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b111, 3'b111));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        // staged presses while stage held, release arms them
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b101, 3'b010));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b001, 3'b100));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        // direct press while armed, then commit on clock edge
        drive_item(panel_item(OP_TICK, 1'b0, 3'b010, 3'b000));
        drive_item(panel_item(OP_EDGE, 1'b0, 3'b000, 3'b000));
        drive_item(panel_item(OP_EDGE, 1'b0, 3'b000, 3'b000));
        // arm, then hold again: edge must not commit while held, release does
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b111, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_EDGE, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));

        // --- zero timeout, zero divisor (rotate every tick), full seed ---
        settle();
        load_settings(16'd0, 8'd0, 6'h3F);
        drive_item(panel_item(OP_TICK, 1'b1, 3'b001, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        // second tick of the hold discards the armed set
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b1, 3'b000, 3'b000));
        drive_item(panel_item(OP_TICK, 1'b0, 3'b000, 3'b000));
        drive_item(panel_item(OP_EDGE, 1'b0, 3'b000, 3'b000));

        // --- random phases, each with its own register settings ---
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0: begin
                    tmo  = 16'hFFFF;
                    div  = 8'hFF;
                    seed = 6'd0;
                end
                1: begin
                    tmo  = 16'd1;
                    div  = 8'd1;
                    seed = 6'h3F;
                end
                default: begin
                    case ($urandom_range(3))
                        0:       tmo = 16'd0;
                        1:       tmo = 16'($urandom_range(2, 12));
                        2:       tmo = 16'($urandom_range(13, 40));
                        default: tmo = HOLD_TIMEOUT_RST;
                    endcase
                    case ($urandom_range(3))
                        0:       div = 8'd0;
                        1:       div = 8'd1;
                        2:       div = 8'($urandom_range(2, 8));
                        default: div = BLINK_DIVISOR_RST;
                    endcase
                    seed = 6'($urandom_range(63));
                end
            endcase
            load_settings(tmo, div, seed);

            // one phase runs without any idling on either side
            gaps_on   = (phase != 4);
            phase_end = items_sent + 200;
            while (items_sent < phase_end) begin
                if (phase == 2 && !pressure_done && items_sent >= phase_end - 100) begin
                    stall_left    = 80;
                    pressure_done = 1'b1;
                end
                if ($urandom_range(9) < 7)
                    staged_sequence();
                else
                    noise_item();
            end
        end

        settle();
        repeat (5) @(negedge clk);

        $display("Checked %0d results from %0d ticks and %0d clock edges under %0d settings.",
                 shadow.checked, shadow.n_ticks, shadow.n_edges, n_settings);
        $display("Staged sets: %0d armed, %0d committed, %0d dropped on hold timeout.",
                 shadow.n_armed, shadow.n_committed, shadow.n_discarded);
        if (shadow.errors == 0 && shadow.owed_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
